// File: rtl/core/qpx_pkg.sv
// shared types, constants and helpers of the query parameter extractor
`timescale 1ns / 1ps

package qpx_pkg;

  localparam int unsigned NameMaxChars = 8;
  localparam int unsigned KeyIdxW      = $clog2(NameMaxChars);
  localparam int unsigned JoinRawMax   = 511;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);

  // characters of the query syntax
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChSpace   = 8'h20;

  // configuration register indexes
  localparam logic [1:0] CfgKeyChars  = 2'd0;
  localparam logic [1:0] CfgKeyLength = 2'd1;
  localparam logic [1:0] CfgOutLimit  = 2'd2;
  localparam logic [1:0] CfgJoinMode  = 2'd3;

  typedef struct packed {
    logic [63:0] key_chars;
    logic [3:0]  key_length;
    logic [16:0] out_limit;
    logic        join_mode;
  } cfg_t;

  // up to three results caused by one input transaction
  typedef struct packed {
    logic [1:0]      cnt;
    logic            rpt;
    logic            found;
    logic [2:0][7:0] bytes;
  } bundle_t;

  // {valid, nibble}; nibble is zero for a non-hex character
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/qpx_front.sv
// front end: key matching, percent decoding and output budget per query byte
`timescale 1ns / 1ps

module qpx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qpx_pkg::cfg_t      cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         query_byte_i,
  input  logic               string_end_i,
  output qpx_pkg::bundle_t   bundle_o
);

  logic [3:0]  key_idx_q, key_idx_d;
  logic        key_match_q, key_match_d;
  logic        in_val_q, in_val_d;
  logic        val_sel_q, val_sel_d;
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic [7:0]  pend_byte_q, pend_byte_d;
  logic [16:0] raw_cnt_q, raw_cnt_d;
  logic [16:0] out_cnt_q, out_cnt_d;
  logic        first_seen_q, first_seen_d;

  logic [qpx_pkg::NameMaxChars-1:0][7:0] key_bytes;
  logic [3:0]  klen;
  logic [16:0] lim1, cap, avail, out_sum;
  logic [4:0]  hc, hp;
  logic [7:0]  c, want, plain_byte;
  logic [7:0]  s0, s1, c0, c1, c2;
  logic [1:0]  ns, fn;
  logic [2:0]  ncand, na, total;
  logic        fl_en;

  assign key_bytes  = cfg_i.key_chars;
  assign c          = query_byte_i;
  assign klen       = (cfg_i.key_length > 4'(qpx_pkg::NameMaxChars)) ?
                      4'(qpx_pkg::NameMaxChars) : cfg_i.key_length;
  assign lim1       = (cfg_i.out_limit == 17'd0) ? 17'd0 : cfg_i.out_limit - 17'd1;
  assign cap        = cfg_i.join_mode ? 17'(qpx_pkg::JoinRawMax) : lim1;
  assign want       = key_bytes[key_idx_q[qpx_pkg::KeyIdxW-1:0]];
  assign hc         = qpx_pkg::hex_val(c);
  assign hp         = qpx_pkg::hex_val(pend_byte_q);
  assign plain_byte = (c == qpx_pkg::ChPlus) ? qpx_pkg::ChSpace : c;

  // parse state update and the bytes this step wants to emit
  always_comb begin
    key_idx_d    = key_idx_q;
    key_match_d  = key_match_q;
    in_val_d     = in_val_q;
    val_sel_d    = val_sel_q;
    pend_cnt_d   = pend_cnt_q;
    pend_byte_d  = pend_byte_q;
    raw_cnt_d    = raw_cnt_q;
    first_seen_d = first_seen_q;
    ns           = 2'd0;
    s0           = qpx_pkg::ChPercent;
    s1           = pend_byte_q;

    if (c == qpx_pkg::ChAmp) begin
      // flush an unfinished escape of a selected value
      if (in_val_q && val_sel_q) begin
        ns = (pend_cnt_q == 2'd1) ? 2'd1 : (pend_cnt_q == 2'd2) ? 2'd2 : 2'd0;
      end
      key_idx_d   = 4'd0;
      key_match_d = 1'b1;
      in_val_d    = 1'b0;
      val_sel_d   = 1'b0;
      pend_cnt_d  = 2'd0;
      pend_byte_d = 8'd0;
      raw_cnt_d   = 17'd0;
    end else if (!in_val_q) begin
      if (key_idx_q < klen) begin
        if (key_match_q && c == want) begin
          key_idx_d = key_idx_q + 4'd1;
        end else begin
          key_match_d = 1'b0;
          in_val_d    = 1'b1;
          val_sel_d   = 1'b0;
        end
      end else if (key_match_q && c == qpx_pkg::ChEq) begin
        in_val_d     = 1'b1;
        val_sel_d    = 1'b0;
        raw_cnt_d    = 17'd0;
        pend_cnt_d   = 2'd0;
        pend_byte_d  = 8'd0;
        first_seen_d = 1'b1;
        if (cfg_i.out_limit != 17'd0) begin
          if (cfg_i.join_mode) begin
            val_sel_d = 1'b1;
            if (out_cnt_q != 17'd0) begin
              ns = 2'd1;
              s0 = qpx_pkg::ChComma;
            end
          end else begin
            val_sel_d = !first_seen_q;
          end
        end
      end else begin
        key_match_d = 1'b0;
        in_val_d    = 1'b1;
        val_sel_d   = 1'b0;
      end
    end else if (val_sel_q && raw_cnt_q < cap) begin
      raw_cnt_d = raw_cnt_q + 17'd1;
      case (pend_cnt_q)
        2'd1: begin
          if (hc[4]) begin
            pend_byte_d = c;
            pend_cnt_d  = 2'd2;
          end else begin
            // lone percent goes out literally, then the byte as usual
            pend_cnt_d = 2'd0;
            s0         = qpx_pkg::ChPercent;
            if (c == qpx_pkg::ChPercent) begin
              pend_cnt_d = 2'd1;
              ns         = 2'd1;
            end else begin
              s1 = plain_byte;
              ns = 2'd2;
            end
          end
        end
        2'd2: begin
          pend_cnt_d = 2'd0;
          s0         = hc[4] ? {hp[3:0], hc[3:0]} : {4'd0, hp[3:0]};
          ns         = 2'd1;
        end
        default: begin
          pend_cnt_d = 2'd0;
          if (c == qpx_pkg::ChPercent) begin
            pend_cnt_d = 2'd1;
          end else begin
            s0 = plain_byte;
            ns = 2'd1;
          end
        end
      endcase
    end
  end

  // end-of-string flush, candidate list and output budget
  always_comb begin
    fl_en = string_end_i && in_val_d && val_sel_d;
    fn    = !fl_en ? 2'd0 : (pend_cnt_d == 2'd1) ? 2'd1 :
            (pend_cnt_d == 2'd2) ? 2'd2 : 2'd0;
    ncand = {1'b0, ns} + {1'b0, fn};
    c0    = (ns != 2'd0) ? s0 : qpx_pkg::ChPercent;
    c1    = (ns == 2'd2) ? s1 : (ns == 2'd1) ? qpx_pkg::ChPercent : pend_byte_d;
    c2    = (ns == 2'd2) ? qpx_pkg::ChPercent : pend_byte_d;
    avail = (out_cnt_q >= lim1) ? 17'd0 : lim1 - out_cnt_q;
    na    = (avail < {14'd0, ncand}) ? avail[2:0] : ncand;
    out_sum = out_cnt_q + {14'd0, na};
    total = na + {2'd0, string_end_i};

    bundle_o.cnt   = (total > 3'd3) ? 2'd3 : total[1:0];
    bundle_o.rpt   = string_end_i && (na < 3'd3);
    bundle_o.found = (cfg_i.out_limit == 17'd0) ? 1'b0 :
                     cfg_i.join_mode ? (out_sum != 17'd0) : first_seen_d;
    bundle_o.bytes = {c2, c1, c0};

    out_cnt_d = string_end_i ? 17'd0 : out_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_idx_q    <= 4'd0;
      key_match_q  <= 1'b1;
      in_val_q     <= 1'b0;
      val_sel_q    <= 1'b0;
      pend_cnt_q   <= 2'd0;
      pend_byte_q  <= 8'd0;
      raw_cnt_q    <= 17'd0;
      out_cnt_q    <= 17'd0;
      first_seen_q <= 1'b0;
    end else if (accept_i) begin
      out_cnt_q <= out_cnt_d;
      if (string_end_i) begin
        key_idx_q    <= 4'd0;
        key_match_q  <= 1'b1;
        in_val_q     <= 1'b0;
        val_sel_q    <= 1'b0;
        pend_cnt_q   <= 2'd0;
        pend_byte_q  <= 8'd0;
        raw_cnt_q    <= 17'd0;
        first_seen_q <= 1'b0;
      end else begin
        key_idx_q    <= key_idx_d;
        key_match_q  <= key_match_d;
        in_val_q     <= in_val_d;
        val_sel_q    <= val_sel_d;
        pend_cnt_q   <= pend_cnt_d;
        pend_byte_q  <= pend_byte_d;
        raw_cnt_q    <= raw_cnt_d;
        first_seen_q <= first_seen_d;
      end
    end
  end

  a_key_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_idx_q <= 4'(qpx_pkg::NameMaxChars))
    else $error("key index past name length");

  a_escape_only_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !val_sel_q |-> (pend_cnt_q == 2'd0))
    else $error("escape pending outside a selected value");

endmodule

// File: rtl/core/qpx_fifo.sv
// short queue of result bundles between front and back
`timescale 1ns / 1ps

module qpx_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  qpx_pkg::bundle_t wr_data_i,
  input  logic             rd_en_i,
  output qpx_pkg::bundle_t rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  qpx_pkg::bundle_t                 mem_q [qpx_pkg::FifoDepth];
  logic [qpx_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [qpx_pkg::FifoCntW-1:0]     cnt_q;

  assign full_o    = (cnt_q == qpx_pkg::FifoCntW'(qpx_pkg::FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + qpx_pkg::FifoPtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + qpx_pkg::FifoPtrW'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + qpx_pkg::FifoCntW'(1);
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - qpx_pkg::FifoCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (!full_o || rd_en_i))
    else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("bundle queue underflow");

endmodule

// File: rtl/core/qpx_back.sv
// back end: unpacks bundles into single results behind an output register
`timescale 1ns / 1ps

module qpx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qpx_pkg::bundle_t head_i,
  input  logic             head_empty_i,
  output logic             head_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             result_kind_o,
  output logic [7:0]       value_byte_o,
  output logic             found_o,
  output logic             last_o
);

  logic [1:0] pos_q;
  logic       out_valid_q;
  logic       kind_q, found_q, last_q;
  logic [7:0] byte_q;
  logic       load, take, is_last, is_rpt;
  logic [7:0] sel_byte;

  assign load    = !out_valid_q || pop_i;
  assign take    = load && !head_empty_i;
  assign is_last = (pos_q == head_i.cnt - 2'd1);
  assign is_rpt  = head_i.rpt && is_last;
  assign head_pop_o = take && is_last;

  always_comb begin
    case (pos_q)
      2'd0:    sel_byte = head_i.bytes[0];
      2'd1:    sel_byte = head_i.bytes[1];
      default: sel_byte = head_i.bytes[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= take;
      if (take) begin
        pos_q <= is_last ? 2'd0 : pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= is_rpt;
      byte_q  <= is_rpt ? 8'd0 : sel_byte;
      found_q <= is_rpt && head_i.found;
      last_q  <= is_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign result_kind_o = kind_q;
  assign value_byte_o  = byte_q;
  assign found_o       = found_q;
  assign last_o        = last_q;

  a_pos_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> (pos_q < head_i.cnt))
    else $error("unpack position beyond bundle");

  a_pos_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_empty_i |-> (pos_q == 2'd0))
    else $error("unpack position left mid-bundle");

endmodule

// File: rtl/core/query_param_extract_decode_core.sv
// top level of the query parameter extractor with percent decoding
`timescale 1ns / 1ps

// Streams a URL query string in one byte per push transaction, string_end_i
// set on the last byte, and returns the percent-decoded value bytes of every
// key that equals the configured name (first match only, or all matches
// joined by commas), followed by one end-of-string report carrying found.
// A byte is taken in the cycle it is pushed while full is low: the front end
// parses and decodes it in that cycle and queues its results (up to three) as
// one bundle in a four-entry queue; the back end hands out one result per
// cycle while pop is held, from an output register. Items with at most one
// result run at one item per cycle while pop is held; further results go out
// one at a time, which the queue absorbs until it fills and full rises. A
// byte's first result passes the bundle queue, then the output register,
// before it is on the result ports. Registers are to be written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle, which it does not
// enforce: index 0 key_chars, 1 key_length, 2 out_limit, 3 join_mode.

module query_param_extract_decode_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // query byte transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  query_byte_i,
  input  logic        string_end_i,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [7:0]  value_byte_o,
  output logic        found_o,
  output logic        last_o
);

  qpx_pkg::cfg_t    cfg_q;
  qpx_pkg::bundle_t bundle, head;
  logic             accept, fifo_full, fifo_empty, fifo_wr, fifo_rd;

  // configuration registers, reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_chars  <= 64'd0;
      cfg_q.key_length <= 4'd1;
      cfg_q.out_limit  <= 17'd128;
      cfg_q.join_mode  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qpx_pkg::CfgKeyChars:  cfg_q.key_chars  <= cfg_wdata_i;
        qpx_pkg::CfgKeyLength: cfg_q.key_length <= cfg_wdata_i[3:0];
        qpx_pkg::CfgOutLimit:  cfg_q.out_limit  <= cfg_wdata_i[16:0];
        qpx_pkg::CfgJoinMode:  cfg_q.join_mode  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // a byte is taken whenever the bundle queue has room
  assign full    = fifo_full;
  assign accept  = push && !fifo_full;
  // bytes that cause no result leave nothing in the queue
  assign fifo_wr = accept && (bundle.cnt != 2'd0);

  qpx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .query_byte_i (query_byte_i),
    .string_end_i (string_end_i),
    .bundle_o     (bundle)
  );

  qpx_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fifo_wr),
    .wr_data_i (bundle),
    .rd_en_i   (fifo_rd),
    .rd_data_o (head),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  qpx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_empty_i  (fifo_empty),
    .head_pop_o    (fifo_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .result_kind_o (result_kind_o),
    .value_byte_o  (value_byte_o),
    .found_o       (found_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/qpx_value_checker.sv
// checker for the query parameter extractor: predicts decoded values and reports
`timescale 1ns / 1ps

module qpx_value_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  query_byte_i,
  input  logic        string_end_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        result_kind_i,
  input  logic [7:0]  value_byte_i,
  input  logic        found_i,
  input  logic        last_i,
  output int          mismatch_cnt_o,
  output int          awaited_o
);
  import qpx_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       found;
    logic       last;
  } res_t;

  cfg_t        cfg;

  // parser and decoder state
  logic [3:0]  key_pos;
  logic        key_alive;
  logic        in_value;
  logic        taking;
  logic [1:0]  esc_len;
  logic [7:0]  esc_hi;
  logic [16:0] raw_len;
  logic [16:0] out_len;
  logic        match_seen;

  res_t        byte_results [3];
  int          byte_res_n;
  res_t        expected_results [$];
  int          awaited;
  int          mismatches;

  assign awaited_o      = awaited;
  assign mismatch_cnt_o = mismatches;

  function automatic logic [16:0] room();
    return (cfg.out_limit == 17'd0) ? 17'd0 : cfg.out_limit - 17'd1;
  endfunction

  function automatic void put(logic kind, logic [7:0] data, logic fnd);
    if (byte_res_n < 3) begin
      byte_results[byte_res_n] = '{kind, data, fnd, 1'b0};
      byte_res_n++;
    end
  endfunction

  function automatic void emit(logic [7:0] b);
    if (out_len < room()) begin
      put(1'b0, b, 1'b0);
      out_len++;
    end
  endfunction

  function automatic int hex_nib(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void decode_plain(logic [7:0] c);
    if (c == ChPercent) esc_len = 2'd1;
    else if (c == ChPlus) emit(ChSpace);
    else emit(c);
  endfunction

  function automatic void decode_feed(logic [7:0] c);
    int hi;
    int lo;
    int v;
    if (esc_len == 2'd1) begin
      if (hex_nib(c) >= 0) begin
        esc_hi  = c;
        esc_len = 2'd2;
      end else begin
        esc_len = 2'd0;
        emit(ChPercent);
        decode_plain(c);
      end
    end else if (esc_len == 2'd2) begin
      hi = hex_nib(esc_hi);
      lo = hex_nib(c);
      v  = (hi < 0) ? 0 : hi;
      // a non-hex second digit is dropped and the first one stands alone
      if (lo >= 0) v = v * 16 + lo;
      esc_len = 2'd0;
      emit(8'(v));
    end else begin
      esc_len = 2'd0;
      decode_plain(c);
    end
  endfunction

  // an escape cut short by the end of the value comes out literally
  function automatic void decode_flush();
    if (esc_len == 2'd1) begin
      emit(ChPercent);
    end else if (esc_len == 2'd2) begin
      emit(ChPercent);
      emit(esc_hi);
    end
    esc_len = 2'd0;
    esc_hi  = 8'd0;
  endfunction

  function automatic void restart_segment();
    key_pos   = 4'd0;
    key_alive = 1'b1;
    in_value  = 1'b0;
    taking    = 1'b0;
    esc_len   = 2'd0;
    esc_hi    = 8'd0;
    raw_len   = 17'd0;
  endfunction

  function automatic void open_value();
    in_value = 1'b1;
    taking   = 1'b0;
    raw_len  = 17'd0;
    esc_len  = 2'd0;
    esc_hi   = 8'd0;
    if (cfg.out_limit == 17'd0) begin
      match_seen = 1'b1;
      return;
    end
    if (cfg.join_mode) begin
      taking = 1'b1;
      if (out_len > 17'd0) emit(ChComma);
    end else if (!match_seen) begin
      taking = 1'b1;
    end
    match_seen = 1'b1;
  endfunction

  function automatic void skip_segment();
    key_alive = 1'b0;
    in_value  = 1'b1;
    taking    = 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic fin);
    logic [3:0]  klen;
    logic [7:0]  want;
    logic [16:0] cap;
    logic        fnd;
    klen = (cfg.key_length > 4'(NameMaxChars)) ? 4'(NameMaxChars) : cfg.key_length;
    byte_res_n = 0;
    if (c == ChAmp) begin
      if (in_value && taking) decode_flush();
      restart_segment();
    end else if (!in_value) begin
      if (key_pos < klen) begin
        want = cfg.key_chars[key_pos[2:0]*8 +: 8];
        if (key_alive && c == want) key_pos++;
        else skip_segment();
      end else if (key_alive && c == ChEq) begin
        open_value();
      end else begin
        skip_segment();
      end
    end else if (taking) begin
      cap = cfg.join_mode ? 17'(JoinRawMax) : room();
      if (raw_len < cap) begin
        raw_len++;
        decode_feed(c);
      end
    end
    if (fin) begin
      if (in_value && taking) decode_flush();
      if (cfg.out_limit == 17'd0) fnd = 1'b0;
      else if (cfg.join_mode) fnd = (out_len > 17'd0);
      else fnd = match_seen;
      put(1'b1, 8'd0, fnd);
      restart_segment();
      out_len    = 17'd0;
      match_seen = 1'b0;
    end
    if (byte_res_n > 0) byte_results[byte_res_n-1].last = 1'b1;
    for (int i = 0; i < byte_res_n; i++) begin
      expected_results.push_back(byte_results[i]);
      awaited++;
    end
  endfunction

  function automatic void note_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected kind %0d byte %02h found %0d last %0d,",
               $realtime, what, want.kind, want.data, want.found, want.last,
               " got kind %0d byte %02h found %0d last %0d",
               got.kind, got.data, got.found, got.last);
  endfunction

  function automatic void check_result(res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      note_mismatch("unexpected result", '0, got);
    end else begin
      want = expected_results.pop_front();
      awaited--;
      if (got.kind !== want.kind || got.data !== want.data ||
          got.found !== want.found || got.last !== want.last)
        note_mismatch("result mismatch", want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{key_chars: 64'd0, key_length: 4'd1, out_limit: 17'd128, join_mode: 1'b0};
      restart_segment();
      out_len    = 17'd0;
      match_seen = 1'b0;
      expected_results.delete();
      awaited    = 0;
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeyChars:  cfg.key_chars  = cfg_wdata_i;
          CfgKeyLength: cfg.key_length = cfg_wdata_i[3:0];
          CfgOutLimit:  cfg.out_limit  = cfg_wdata_i[16:0];
          CfgJoinMode:  cfg.join_mode  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (push_i && !full_i) predict_byte(query_byte_i, string_end_i);
      if (pop_i && !empty_i) check_result('{result_kind_i, value_byte_i, found_i, last_i});
    end
  end

endmodule

// File: tb/tb_query_param_extract_decode_core.sv
// testbench top: query stimulus, result pacing, watchdog and verdict
`timescale 1ns / 1ps

module tb_query_param_extract_decode_core;
  import qpx_pkg::*;

  localparam int HoldCycles   = 40;    // long receiver hold-off, fills the block
  localparam int SettleCycles = 6;     // margin after the last predicted result
  localparam int StallLimit   = 2000;  // cycles without any transaction

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_idx     = CfgKeyChars;
  logic [63:0] cfg_wdata   = 64'd0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  query_byte  = 8'd0;
  logic        string_end  = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic        result_kind;
  logic [7:0]  value_byte;
  logic        found;
  logic        last;

  int          mismatch_cnt;
  int          awaited;

  // stimulus bookkeeping
  logic [63:0] cur_key   = 64'd0;
  int          cur_len   = 1;
  logic [7:0]  text_q [$];
  int          bytes_sent = 0;
  bit          idle_on    = 1'b1;
  int          hold_asks  = 0;
  int          hold_seen  = 0;
  int          rx_wait    = 0;

  always #5 clk_i = ~clk_i;

  query_param_extract_decode_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .query_byte_i  (query_byte),
    .string_end_i  (string_end),
    .empty         (empty),
    .pop           (pop),
    .result_kind_o (result_kind),
    .value_byte_o  (value_byte),
    .found_o       (found),
    .last_o        (last)
  );

  qpx_value_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push_i         (push),
    .full_i         (full),
    .query_byte_i   (query_byte),
    .string_end_i   (string_end),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_kind_i  (result_kind),
    .value_byte_i   (value_byte),
    .found_i        (found),
    .last_i         (last),
    .mismatch_cnt_o (mismatch_cnt),
    .awaited_o      (awaited)
  );

  // reset held from time zero, released on a falling edge, never again
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // query text construction
  // ---------------------------------------------------------------------------

  function automatic void add_char(logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic logic [7:0] key_byte(int i);
    return cur_key[i*8 +: 8];
  endfunction

  function automatic void add_key(int n);
    for (int i = 0; i < n; i++) add_char(key_byte(i));
  endfunction

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 16) return 8'h61 + 8'(k - 10);
    return 8'h41 + 8'(k - 16);
  endfunction

  // lowercase g..z: never a hex digit, never query syntax
  function automatic logic [7:0] rand_plain();
    return 8'h67 + 8'($urandom_range(0, 19));
  endfunction

  // value text mixing plain bytes, '+', good escapes and broken ones
  function automatic void add_value();
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 7))
        0, 1: add_char(8'h61 + 8'($urandom_range(0, 25)));
        2: add_char(ChPlus);
        3: begin
          add_char(ChPercent);
          add_char(rand_hex());
          add_char(rand_hex());
        end
        4: begin  // second digit not hex: gets dropped
          add_char(ChPercent);
          add_char(rand_hex());
          add_char(rand_plain());
        end
        5: begin  // percent passed through literally
          add_char(ChPercent);
          add_char(rand_plain());
        end
        6: add_char(ChPercent);  // may end up cut by '&' or end of string
        default: add_char(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void add_segment();
    int n;
    int k;
    n = (cur_len > NameMaxChars) ? NameMaxChars : cur_len;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      // exact key, mostly what gets past the key compare
      add_key(n);
      add_char(ChEq);
    end else if (k == 5) begin
      // near miss on the last key byte
      if (n == 0) add_char(rand_plain());
      else begin
        add_key(n - 1);
        add_char(key_byte(n - 1) ^ 8'h01);
      end
      add_char(ChEq);
    end else if (k == 6) begin
      // key followed by one more name byte
      add_key(n);
      add_char(rand_plain());
      add_char(ChEq);
    end else if (k == 7) begin
      // key with no '=' after it
      add_key(n);
      add_char(rand_plain());
    end else if (k == 8) begin
      repeat ($urandom_range(1, 4)) add_char(rand_plain());
      add_char(ChEq);
    end else begin
      // truncated key
      add_key((n > 1) ? n - 1 : 0);
      add_char(ChEq);
    end
    add_value();
  endfunction

  function automatic void make_query();
    int segs;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // pure noise
      repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
    end else begin
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
        if (s > 0) add_char(ChAmp);
        add_segment();
      end
      if ($urandom_range(0, 7) == 0) add_char(ChAmp);
    end
    if (text_q.size() == 0) add_char(rand_plain());
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one push transaction; called and left on a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    push       <= 1'b1;
    query_byte <= b;
    string_end <= fin;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic run_queries(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_query();
      send_text();
    end
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    push <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] key, input int len, input int limit,
                            input bit join_all);
    settle();
    cur_key = key;
    cur_len = len;
    write_reg(CfgKeyChars, key);
    write_reg(CfgKeyLength, 64'(len));
    write_reg(CfgOutLimit, 64'(limit));
    write_reg(CfgJoinMode, 64'(join_all));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts plus a requested long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        rx_wait   = HoldCycles;
      end else if (rx_wait == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        rx_wait = $urandom_range(1, 13);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a stretch of StallLimit cycles with no transaction on either side ends the run
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus phases and verdict
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    wait (rst_ni);
    @(negedge clk_i);

    // directed: key "ab", first mode
    set_config(64'h0000_0000_0000_6261, 2, 128, 1'b0);
    // escape, plus, dropped digit, literal percent, escape cut by end of string
    text_q.delete();
    add_str("ab=%41+%4g%z%4");
    send_text();
    // zero and all-ones bytes, second match ignored, lone percent at the end
    text_q.delete();
    add_str("ab=");
    add_char(8'h00);
    add_char(8'hFF);
    add_str("&ab=2%");
    send_text();

    // first mode with a short buffer: raw value bytes cut
    set_config(64'h0000_0000_0067_6174, 3, 6, 1'b0);
    run_queries(15);

    // join mode, long receiver hold-off while the sender keeps pushing
    set_config(64'h0000_0000_0067_6174, 3, 20, 1'b1);
    hold_asks++;
    run_queries(25);

    // full eight-byte name, largest useful buffer, long value
    set_config(64'h657a_6973_6567_6170, 8, 65536, 1'b1);
    text_q.delete();
    add_key(8);
    add_char(ChEq);
    repeat (24) add_char(8'h61 + 8'($urandom_range(0, 25)));
    add_char(ChAmp);
    add_key(8);
    add_char(ChEq);
    add_str("ok");
    send_text();
    run_queries(5);

    // name length above eight counts as eight; buffer of one emits nothing
    set_config(64'h657a_6973_6567_6170, 15, 1, 1'b0);
    run_queries(5);

    // zero buffer: never found
    set_config(64'h657a_6973_6567_6170, 8, 0, 1'($urandom_range(0, 1)));
    run_queries(5);

    // empty name: segments starting with '=' match
    set_config(64'h0, 0, 128, 1'b1);
    run_queries(10);

    // name holding '&' can never match
    set_config(64'h0000_0000_0000_2661, 2, 128, 1'b0);
    run_queries(5);

    // all-ones name bytes, widest buffer value
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 8, 131071, 1'b0);
    run_queries(5);

    // closing stretch with no idling on either side
    set_config({48'h0, 8'h61 + 8'($urandom_range(0, 25)), 8'h61 + 8'($urandom_range(0, 25))},
               2, $urandom_range(2, 40), 1'b1);
    idle_on = 1'b0;
    run_queries(20);

    settle();
    if (mismatch_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/qpx_pkg.sv
rtl/core/qpx_front.sv
rtl/core/qpx_fifo.sv
rtl/core/qpx_back.sv
rtl/core/query_param_extract_decode_core.sv
tb/qpx_value_checker.sv
tb/tb_query_param_extract_decode_core.sv
